[sv/mkid_pkg.sv]
// mkid_pkg: shared widths, types and codes for the matrix key debouncer
// no dependencies; used by mkid_key_cell, mkid_key_matrix and the top level
package mkid_pkg;

   localparam int ROWS         = 3;
   localparam int KEYS_PER_ROW = 3;
   localparam int NKEYS        = ROWS * KEYS_PER_ROW;

   localparam int CNT_W      = 4;
   localparam int ROW_W      = 2;
   localparam int SAMPLE_W   = 3;
   localparam int KEY_W      = 4;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 4;

   typedef logic [CNT_W-1:0] count_type;

   typedef struct packed {
      count_type count_floor;
      count_type count_ceiling;
      count_type press_level;
      count_type release_level;
   } cfg_type;

   typedef struct packed {
      logic             valid;
      logic [KEY_W-1:0] key;
   } event_type;

   localparam count_type COUNTER_RESET = 4'd2;
   localparam count_type FLOOR_RESET   = 4'd2;
   localparam count_type CEILING_RESET = 4'd6;
   localparam count_type PRESS_RESET   = 4'd5;
   localparam count_type RELEASE_RESET = 4'd3;

   localparam cfg_type CFG_RESET = '{
      count_floor:   FLOOR_RESET,
      count_ceiling: CEILING_RESET,
      press_level:   PRESS_RESET,
      release_level: RELEASE_RESET
   };

   localparam event_type NO_EVENT = '0;

   // opcodes
   localparam logic OP_SCAN = 1'b0;
   localparam logic OP_READ = 1'b1;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_COUNT_FLOOR   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COUNT_CEILING = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PRESS_LEVEL   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RELEASE_LEVEL = 2'd3;

endpackage

[sv/mkid_key_cell.sv]
// mkid_key_cell: integrating counter and pressed flag of one key
// depends on mkid_pkg
module mkid_key_cell (
   input  logic              clock,
   input  logic              reset,
   input  logic              step_en,
   input  logic              sample,
   input  mkid_pkg::cfg_type cfg,
   output logic              press
);

   mkid_pkg::count_type          cnt_ff;
   mkid_pkg::count_type          cnt_in;
   logic                         pressed_ff;
   logic                         pressed_in;
   logic [mkid_pkg::CNT_W:0]     up_sum;
   logic [mkid_pkg::CNT_W:0]     dn_diff;
   logic [mkid_pkg::CNT_W:0]     stepped;
   logic [mkid_pkg::CNT_W:0]     clamped;
   logic [mkid_pkg::CNT_W:0]     floor_x;
   logic [mkid_pkg::CNT_W:0]     ceil_x;
   logic                         below_floor;
   mkid_pkg::count_type          cnt_new;
   logic                         pressed_mid;

   always_comb begin
      floor_x = {1'b0, cfg.count_floor};
      ceil_x  = {1'b0, cfg.count_ceiling};
      up_sum  = {1'b0, cnt_ff} + {{mkid_pkg::CNT_W{1'b0}}, 1'b1};
      dn_diff = {1'b0, cnt_ff} - {{mkid_pkg::CNT_W{1'b0}}, 1'b1};
      if (sample) begin
         stepped     = up_sum;
         below_floor = (up_sum < floor_x);
      end else begin
         stepped     = dn_diff;
         // stepping down from zero goes below any floor
         below_floor = (cnt_ff == '0) || (dn_diff < floor_x);
      end
      clamped = below_floor ? floor_x : stepped;
      if (clamped > ceil_x) begin
         clamped = ceil_x;
      end
      cnt_new = clamped[mkid_pkg::CNT_W-1:0];

      // release test first, then press test
      pressed_mid = pressed_ff && !(cnt_new < cfg.release_level);
      press       = step_en && !pressed_mid && (cnt_new > cfg.press_level);

      cnt_in     = step_en ? cnt_new : cnt_ff;
      pressed_in = step_en ? (pressed_mid || press) : pressed_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff     <= mkid_pkg::COUNTER_RESET;
         pressed_ff <= 1'b0;
      end else begin
         cnt_ff     <= cnt_in;
         pressed_ff <= pressed_in;
      end
   end

endmodule

[sv/mkid_key_matrix.sv]
// mkid_key_matrix: one key cell per key, row decode and press event select
// depends on mkid_pkg and mkid_key_cell
module mkid_key_matrix (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          scan_en,
   input  logic [mkid_pkg::ROW_W-1:0]    row_index,
   input  logic [mkid_pkg::SAMPLE_W-1:0] column_samples,
   input  mkid_pkg::cfg_type             cfg,
   output mkid_pkg::event_type           scan_event
);

   logic [mkid_pkg::NKEYS-1:0]        press;
   logic [mkid_pkg::ROWS-1:0]         row_hit;
   logic [mkid_pkg::KEYS_PER_ROW-1:0] col_sample;

   for (genvar c = 0; c < mkid_pkg::KEYS_PER_ROW; c++) begin : g_col
      if (c < mkid_pkg::SAMPLE_W) begin : g_bit
         assign col_sample[c] = column_samples[c];
      end else begin : g_none
         assign col_sample[c] = 1'b0;
      end
   end

   for (genvar r = 0; r < mkid_pkg::ROWS; r++) begin : g_row
      assign row_hit[r] = scan_en && (int'(row_index) == r);
      for (genvar c = 0; c < mkid_pkg::KEYS_PER_ROW; c++) begin : g_key
         mkid_key_cell u_cell (
            .clock   (clock),
            .reset   (reset),
            .step_en (row_hit[r]),
            .sample  (col_sample[c]),
            .cfg     (cfg),
            .press   (press[r * mkid_pkg::KEYS_PER_ROW + c])
         );
      end
   end

   // last pressing key of the row wins
   always_comb begin
      scan_event = mkid_pkg::NO_EVENT;
      for (int k = 0; k < mkid_pkg::NKEYS; k++) begin
         if (press[k]) begin
            scan_event.valid = 1'b1;
            scan_event.key   = mkid_pkg::KEY_W'(k);
         end
      end
   end

endmodule

[sv/matrix_key_integrating_debounce_top.sv]
// matrix_key_integrating_debounce_top: key matrix debouncer with csr port
// depends on mkid_pkg and mkid_key_matrix
//
//   channel   direction   handshake                fields
//   req       in          req_valid / req_stall    opcode, row_index, column_samples
//   rsp       out         rsp_valid / rsp_stall    event_valid, event_key
//   csr       in          csr_write_en             csr_index, csr_wdata
//
// one item per cycle unless rsp_stall holds; results come from the result register
// input register feeds the key cells; counters update as the result is registered
// synchronous reset puts counters at two, flags released, csr at reset values
// rsp_stall holds the result register, and req_stall rises once the input
// register is also full, so at most two items are in flight
module matrix_key_integrating_debounce_top (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_opcode,
   input  logic [mkid_pkg::ROW_W-1:0]      req_row_index,
   input  logic [mkid_pkg::SAMPLE_W-1:0]   req_column_samples,
   // response channel
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_event_valid,
   output logic [mkid_pkg::KEY_W-1:0]      rsp_event_key,
   // configuration write port
   input  logic                            csr_write_en,
   input  logic [mkid_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [mkid_pkg::CSR_DATA_W-1:0] csr_wdata
);

   // configuration registers
   mkid_pkg::cfg_type   cfg_ff;
   mkid_pkg::cfg_type   cfg_in;

   // input register
   logic                          s1_valid_ff;
   logic                          s1_valid_in;
   logic                          s1_opcode_ff;
   logic [mkid_pkg::ROW_W-1:0]    s1_row_ff;
   logic [mkid_pkg::SAMPLE_W-1:0] s1_samples_ff;
   logic                          s1_load;

   // pending event and result register
   mkid_pkg::event_type pending_ff;
   mkid_pkg::event_type pending_in;
   mkid_pkg::event_type rsp_ff;
   mkid_pkg::event_type rsp_in;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;

   logic                out_free;
   logic                advance;
   logic                scan_go;
   mkid_pkg::event_type scan_event;

   // handshake control
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;
   assign s1_load   = req_valid && !req_stall;
   assign scan_go   = advance && (s1_opcode_ff == mkid_pkg::OP_SCAN);

   assign s1_valid_in  = req_stall ? s1_valid_ff : req_valid;
   assign rsp_valid_in = out_free ? advance : rsp_valid_ff;

   // csr decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            mkid_pkg::CSR_COUNT_FLOOR:   cfg_in.count_floor   = csr_wdata;
            mkid_pkg::CSR_COUNT_CEILING: cfg_in.count_ceiling = csr_wdata;
            mkid_pkg::CSR_PRESS_LEVEL:   cfg_in.press_level   = csr_wdata;
            mkid_pkg::CSR_RELEASE_LEVEL: cfg_in.release_level = csr_wdata;
            default:                     cfg_in = cfg_ff;
         endcase
      end
   end

   // key cells, updated as the scan leaves the input register
   mkid_key_matrix u_matrix (
      .clock          (clock),
      .reset          (reset),
      .scan_en        (scan_go),
      .row_index      (s1_row_ff),
      .column_samples (s1_samples_ff),
      .cfg            (cfg_ff),
      .scan_event     (scan_event)
   );

   // scan: report and keep the new event; read: report the pending one, then clear
   always_comb begin
      pending_in = pending_ff;
      rsp_in     = rsp_ff;
      if (advance) begin
         if (s1_opcode_ff == mkid_pkg::OP_SCAN) begin
            pending_in = scan_event;
            rsp_in     = scan_event;
         end else begin
            pending_in = mkid_pkg::NO_EVENT;
            rsp_in     = pending_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= mkid_pkg::CFG_RESET;
         s1_valid_ff  <= 1'b0;
         pending_ff   <= mkid_pkg::NO_EVENT;
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         s1_valid_ff  <= s1_valid_in;
         pending_ff   <= pending_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_opcode_ff  <= req_opcode;
         s1_row_ff     <= req_row_index;
         s1_samples_ff <= req_column_samples;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_event_valid = rsp_ff.valid;
   assign rsp_event_key   = rsp_ff.key;

   // checks
   a_key_zero_when_no_event: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.valid |-> rsp_ff.key == '0)
      else $error("event key nonzero without event");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff)
      else $error("request stalled with empty input register");

   a_read_clears_pending: assert property (@(posedge clock) disable iff (reset)
      advance && (s1_opcode_ff == mkid_pkg::OP_READ) |=> !pending_ff.valid)
      else $error("pending event survived a read");

   a_advance_fills_output: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("item left input register without a result");

   a_pending_key_zero: assert property (@(posedge clock) disable iff (reset)
      !pending_ff.valid |-> pending_ff.key == '0)
      else $error("pending key nonzero without event");

endmodule

[bench/tb_matrix_key_integrating_debounce_top.sv]
`timescale 1ns / 1ps
// tb_matrix_key_integrating_debounce_top: self-checking bench for the key matrix debouncer
// depends on mkid_pkg and matrix_key_integrating_debounce_top; walks a directed scan list,
// then random scan and read traffic under several csr settings, checked by a local debounce model
module tb_matrix_key_integrating_debounce_top;

   localparam int CYCLE_LIMIT     = 400000;
   localparam int ITEMS_PER_PHASE = 102;
   localparam int PHASES          = 11;
   localparam int LONG_HOLD       = 150;
   localparam int SETTLE_CYCLES   = 8;

   // one row of the directed scan list; want_* is only used when typed_in is set
   typedef struct packed {
      logic                          opcode;
      logic [mkid_pkg::ROW_W-1:0]    row;
      logic [mkid_pkg::SAMPLE_W-1:0] samples;
      logic                          typed_in;
      logic                          want_valid;
      logic [mkid_pkg::KEY_W-1:0]    want_key;
   } directed_row_type;

   localparam directed_row_type DIRECTED_SCANS [25] = '{
      // after reset: nothing pending, out of range row does nothing
      '{mkid_pkg::OP_READ, 2'd0, 3'd0, 1'b1, 1'b0, 4'd0},
      '{mkid_pkg::OP_SCAN, 2'd3, 3'd7, 1'b1, 1'b0, 4'd0},
      // row 0 held: counters climb 3, 4, 5, then 6 crosses the press level
      '{mkid_pkg::OP_SCAN, 2'd0, 3'd7, 1'b1, 1'b0, 4'd0},
      '{mkid_pkg::OP_SCAN, 2'd0, 3'd7, 1'b1, 1'b0, 4'd0},
      '{mkid_pkg::OP_SCAN, 2'd0, 3'd7, 1'b1, 1'b0, 4'd0},
      // all three keys press at once, the last column wins
      '{mkid_pkg::OP_SCAN, 2'd0, 3'd7, 1'b1, 1'b1, 4'd2},
      // pinned at the ceiling and already pressed: no new event
      '{mkid_pkg::OP_SCAN, 2'd0, 3'd7, 1'b1, 1'b0, 4'd0},
      '{mkid_pkg::OP_READ, 2'd0, 3'd0, 1'b1, 1'b0, 4'd0},
      // one key of row 2 held, the other two pushed against the floor
      '{mkid_pkg::OP_SCAN, 2'd2, 3'd1, 1'b0, 1'b0, 4'd0},
      '{mkid_pkg::OP_SCAN, 2'd2, 3'd1, 1'b0, 1'b0, 4'd0},
      '{mkid_pkg::OP_SCAN, 2'd2, 3'd1, 1'b0, 1'b0, 4'd0},
      '{mkid_pkg::OP_SCAN, 2'd2, 3'd1, 1'b0, 1'b0, 4'd0},
      // read returns the event once, then clears it
      '{mkid_pkg::OP_READ, 2'd0, 3'd0, 1'b0, 1'b0, 4'd0},
      '{mkid_pkg::OP_READ, 2'd0, 3'd0, 1'b0, 1'b0, 4'd0},
      // row 0 let go until it drops under the release level
      '{mkid_pkg::OP_SCAN, 2'd0, 3'd0, 1'b0, 1'b0, 4'd0},
      '{mkid_pkg::OP_SCAN, 2'd0, 3'd0, 1'b0, 1'b0, 4'd0},
      '{mkid_pkg::OP_SCAN, 2'd0, 3'd0, 1'b0, 1'b0, 4'd0},
      '{mkid_pkg::OP_SCAN, 2'd0, 3'd0, 1'b0, 1'b0, 4'd0},
      // middle key of row 1
      '{mkid_pkg::OP_SCAN, 2'd1, 3'd2, 1'b0, 1'b0, 4'd0},
      '{mkid_pkg::OP_SCAN, 2'd1, 3'd2, 1'b0, 1'b0, 4'd0},
      '{mkid_pkg::OP_SCAN, 2'd1, 3'd2, 1'b0, 1'b0, 4'd0},
      '{mkid_pkg::OP_SCAN, 2'd1, 3'd2, 1'b0, 1'b0, 4'd0},
      // out of range scan still wipes the pending event
      '{mkid_pkg::OP_SCAN, 2'd3, 3'd0, 1'b0, 1'b0, 4'd0},
      '{mkid_pkg::OP_READ, 2'd0, 3'd0, 1'b0, 1'b0, 4'd0},
      '{mkid_pkg::OP_SCAN, 2'd0, 3'd5, 1'b0, 1'b0, 4'd0}
   };

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_stall;
   logic                            req_opcode = mkid_pkg::OP_SCAN;
   logic [mkid_pkg::ROW_W-1:0]      req_row_index = '0;
   logic [mkid_pkg::SAMPLE_W-1:0]   req_column_samples = '0;
   logic                            rsp_valid;
   logic                            rsp_stall = 1'b0;
   logic                            rsp_event_valid;
   logic [mkid_pkg::KEY_W-1:0]      rsp_event_key;
   logic                            csr_write_en = 1'b0;
   logic [mkid_pkg::CSR_IDX_W-1:0]  csr_index = mkid_pkg::CSR_COUNT_FLOOR;
   logic [mkid_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   // debounce model state
   mkid_pkg::cfg_type   cfg_model;
   mkid_pkg::count_type count_model [mkid_pkg::NKEYS];
   logic                held_model [mkid_pkg::NKEYS];
   mkid_pkg::event_type pending_model;

   mkid_pkg::event_type expected_events [$];
   mkid_pkg::event_type wanted;
   int                  mismatch_count = 0;
   int                  cycle_count = 0;

   // traffic shaping state of sender and receiver
   logic idle_on = 1'b1;
   int   long_hold_ticket = 0;
   int   long_hold_served = 0;
   int   hold_left = 0;
   int   burst_left = 0;
   int   calm_left = 0;

   // per-row key pattern the random scans mostly follow, so counters get to move
   logic [mkid_pkg::SAMPLE_W-1:0] row_pattern [mkid_pkg::ROWS];

   matrix_key_integrating_debounce_top dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_opcode         (req_opcode),
      .req_row_index      (req_row_index),
      .req_column_samples (req_column_samples),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_event_valid    (rsp_event_valid),
      .rsp_event_key      (rsp_event_key),
      .csr_write_en       (csr_write_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   task automatic report_mismatch(input string what);
      $display("mismatch at cycle %0d: %s", cycle_count, what);
      mismatch_count++;
   endtask

   // advance the model by one accepted item and return the result it reports
   function automatic mkid_pkg::event_type debounce_step(
         input logic op, input logic [mkid_pkg::ROW_W-1:0] row,
         input logic [mkid_pkg::SAMPLE_W-1:0] samples);
      mkid_pkg::event_type reported;
      int                  idx;
      int                  level;
      if (op == mkid_pkg::OP_READ) begin
         reported = pending_model;
         pending_model = mkid_pkg::NO_EVENT;
         return reported;
      end
      pending_model = mkid_pkg::NO_EVENT;
      if (int'(row) < mkid_pkg::ROWS) begin
         for (int col = 0; col < mkid_pkg::KEYS_PER_ROW; col++) begin
            idx = int'(row) * mkid_pkg::KEYS_PER_ROW + col;
            // step without wraparound, floor clamp first so the ceiling wins
            level = int'(count_model[idx]) + (samples[col] ? 1 : -1);
            if (level < int'(cfg_model.count_floor))
               level = int'(cfg_model.count_floor);
            if (level > int'(cfg_model.count_ceiling))
               level = int'(cfg_model.count_ceiling);
            count_model[idx] = mkid_pkg::count_type'(level);
            // release is tested before press, both may fire in one scan
            if (count_model[idx] < cfg_model.release_level && held_model[idx])
               held_model[idx] = 1'b0;
            if (count_model[idx] > cfg_model.press_level && !held_model[idx]) begin
               held_model[idx] = 1'b1;
               pending_model.valid = 1'b1;
               pending_model.key = mkid_pkg::KEY_W'(idx);
            end
         end
      end
      return pending_model;
   endfunction

   // offer one item, optionally after a random gap, and log its expectation on transfer
   task automatic send_item(input logic op, input logic [mkid_pkg::ROW_W-1:0] row,
                            input logic [mkid_pkg::SAMPLE_W-1:0] samples,
                            input logic typed_in,
                            input mkid_pkg::event_type typed_event, input logic allow_gap);
      mkid_pkg::event_type predicted;
      if (allow_gap && idle_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= op;
      req_row_index <= row;
      req_column_samples <= samples;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      // transfer happened at this edge
      predicted = debounce_step(op, row, samples);
      expected_events.push_back(typed_in ? typed_event : predicted);
   endtask

   // stop offering and wait for every expected result, then let the pipe settle
   task automatic drain_block();
      req_valid <= 1'b0;
      while (expected_events.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // csr setting for each random phase: extremes first, then random ones, reset values last
   function automatic mkid_pkg::cfg_type phase_config(input int phase);
      mkid_pkg::cfg_type c;
      case (phase)
         0:       c = '{count_floor: 4'd0,  count_ceiling: 4'd15, press_level: 4'd8,
                        release_level: 4'd7};
         1:       c = '{count_floor: 4'd0,  count_ceiling: 4'd15, press_level: 4'd14,
                        release_level: 4'd1};
         2:       c = '{count_floor: 4'd0,  count_ceiling: 4'd0,  press_level: 4'd0,
                        release_level: 4'd0};
         3:       c = '{count_floor: 4'd15, count_ceiling: 4'd15, press_level: 4'd14,
                        release_level: 4'd15};
         // floor above ceiling, release above press
         4:       c = '{count_floor: 4'd9,  count_ceiling: 4'd4,  press_level: 4'd3,
                        release_level: 4'd6};
         5:       c = '{count_floor: 4'd14, count_ceiling: 4'd14, press_level: 4'd14,
                        release_level: 4'd14};
         6:       c = '{count_floor: 4'd1,  count_ceiling: 4'd7,  press_level: 4'd2,
                        release_level: 4'd6};
         10:      c = mkid_pkg::CFG_RESET;
         default: begin
            c.count_floor   = mkid_pkg::count_type'($urandom_range(0, 15));
            c.count_ceiling = mkid_pkg::count_type'($urandom_range(0, 15));
            c.press_level   = mkid_pkg::count_type'($urandom_range(0, 15));
            c.release_level = mkid_pkg::count_type'($urandom_range(0, 15));
         end
      endcase
      return c;
   endfunction

   // receiver: checks each result transfer, then decides the stall for the next edge
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_events.size() == 0) begin
            report_mismatch($sformatf("result with nothing expected, valid=%0b key=%0d",
                                      rsp_event_valid, rsp_event_key));
         end else begin
            wanted = expected_events.pop_front();
            if (rsp_event_valid !== wanted.valid)
               report_mismatch($sformatf("event_valid got %0b want %0b",
                                         rsp_event_valid, wanted.valid));
            if (rsp_event_key !== wanted.key)
               report_mismatch($sformatf("event_key got %0d want %0d",
                                         rsp_event_key, wanted.key));
         end
      end
      // a new ticket from the sender starts one long hold-off
      if (long_hold_ticket != long_hold_served) begin
         long_hold_served = long_hold_ticket;
         hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (!idle_on) begin
         rsp_stall <= 1'b0;
      end else if (burst_left > 0) begin
         burst_left--;
         rsp_stall <= 1'b1;
      end else if (calm_left > 0) begin
         calm_left--;
         rsp_stall <= 1'b0;
      end else begin
         // alternate stall bursts with calm stretches
         if ($urandom_range(0, 1) == 0) begin
            burst_left = $urandom_range(1, 19) - 1;
            rsp_stall <= 1'b1;
         end else begin
            calm_left = $urandom_range(1, 60);
            rsp_stall <= 1'b0;
         end
      end
   end

   // sender: reset, directed list, then one random phase per csr setting
   initial begin
      directed_row_type              vec;
      mkid_pkg::cfg_type             phase_cfg;
      logic                          op;
      logic [mkid_pkg::ROW_W-1:0]    row;
      logic [mkid_pkg::SAMPLE_W-1:0] samples;
      int                            pick;

      // model starts in its reset state
      cfg_model = mkid_pkg::CFG_RESET;
      pending_model = mkid_pkg::NO_EVENT;
      foreach (count_model[i]) begin
         count_model[i] = mkid_pkg::COUNTER_RESET;
         held_model[i] = 1'b0;
      end
      foreach (row_pattern[i]) row_pattern[i] = '0;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      // directed list runs on the reset csr values
      foreach (DIRECTED_SCANS[i]) begin
         vec = DIRECTED_SCANS[i];
         send_item(vec.opcode, vec.row, vec.samples, vec.typed_in,
                   '{valid: vec.want_valid, key: vec.want_key}, 1'b1);
      end

      for (int phase = 0; phase < PHASES; phase++) begin
         // csr writes only with the block empty
         drain_block();
         phase_cfg = phase_config(phase);
         csr_write_en <= 1'b1;
         csr_index <= mkid_pkg::CSR_COUNT_FLOOR;
         csr_wdata <= phase_cfg.count_floor;
         @(posedge clock);
         cfg_model.count_floor = phase_cfg.count_floor;
         csr_index <= mkid_pkg::CSR_COUNT_CEILING;
         csr_wdata <= phase_cfg.count_ceiling;
         @(posedge clock);
         cfg_model.count_ceiling = phase_cfg.count_ceiling;
         csr_index <= mkid_pkg::CSR_PRESS_LEVEL;
         csr_wdata <= phase_cfg.press_level;
         @(posedge clock);
         cfg_model.press_level = phase_cfg.press_level;
         csr_index <= mkid_pkg::CSR_RELEASE_LEVEL;
         csr_wdata <= phase_cfg.release_level;
         @(posedge clock);
         cfg_model.release_level = phase_cfg.release_level;
         csr_write_en <= 1'b0;
         // last phase runs flat out on both sides
         if (phase == PHASES - 1)
            idle_on <= 1'b0;

         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            // long receiver hold-off while items keep coming, fills the block
            if (phase == 1 && n == 20)
               long_hold_ticket <= long_hold_ticket + 1;
            // sender waits for every outstanding result mid-phase
            if (phase == 3 && n == 50)
               drain_block();

            pick = $urandom_range(0, 99);
            op = mkid_pkg::OP_SCAN;
            row = mkid_pkg::ROW_W'($urandom_range(0, mkid_pkg::ROWS - 1));
            samples = mkid_pkg::SAMPLE_W'($urandom_range(0, 7));
            if (pick < 10) begin
               op = mkid_pkg::OP_READ;
               row = mkid_pkg::ROW_W'($urandom_range(0, 3));
            end else if (pick < 15) begin
               row = mkid_pkg::ROW_W'(3);
            end else if (pick >= 25) begin
               // held pattern with an occasional bouncing contact
               if ($urandom_range(0, 19) == 0)
                  row_pattern[row] = mkid_pkg::SAMPLE_W'($urandom_range(0, 7));
               samples = row_pattern[row];
               if ($urandom_range(0, 7) == 0)
                  samples[$urandom_range(0, mkid_pkg::SAMPLE_W - 1)] ^= 1'b1;
            end
            send_item(op, row, samples, 1'b0, mkid_pkg::NO_EVENT, ((n / 32) % 2) == 0);
         end
      end

      req_valid <= 1'b0;
      while (expected_events.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
